// ===== rtl/core/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  // ASCII '0' in the six bits carried on the output.
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SETUP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic setup;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic last;
    logic out_stall;
  } dp_status_t;

endpackage

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Converts one unsigned VALUE_WIDTH-bit value into ASCII decimal digits, most
// significant first, with leading zeros suppressed (zero gives a single '0');
// last_digit_o marks the final digit of each value. One value is handled at a
// time. The shift-and-add-3 loop takes one input bit per cycle; digits then
// leave one per cycle while the receiver does not stall the output, and the
// next value is accepted while the final digit still waits in the output
// register.
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [VALUE_WIDTH-1:0]      value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0] digit_char_o,
  output logic                        last_digit_o
);
  import b2da_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  b2da_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

// ===== rtl/core/b2da_datapath.sv =====
// Datapath: shift-and-add-3 converter, digit selection and output register.
module b2da_datapath #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  b2da_pkg::ctrl_cmd_t                cmd_i,
  output b2da_pkg::dp_status_t               sts_o,
  input  logic [VALUE_WIDTH-1:0]             value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]        digit_char_o,
  output logic                               last_digit_o
);
  import b2da_pkg::*;

  // Decimal digits of the largest value: floor(W * log10(2)) + 1.
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH);
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       msd;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;
  logic [DIGIT_W-1:0]     cur_digit;

  // Every BCD digit of five or more is corrected before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    msd = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] != '0) begin
        msd = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_q[idx_q*DIGIT_W +: DIGIT_W];

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = CNT_W'(VALUE_WIDTH - 1);
    end
    if (cmd_i.shift) begin
      {bcd_d, bin_d} = {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
      cnt_d          = cnt_q - CNT_W'(1);
    end
    if (cmd_i.setup) begin
      idx_d = msd;
    end
    if (cmd_i.emit) begin
      char_d      = DIGIT_BASE + CHAR_W'(cur_digit);
      last_d      = (idx_q == '0);
      out_valid_d = 1'b1;
      idx_d       = idx_q - IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.conv_done = (cnt_q == '0);
  assign sts_o.last      = (idx_q == '0);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

// ===== rtl/core/b2da_ctrl.sv =====
// Controller: sequences load, conversion, digit setup and digit output.
module b2da_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output b2da_pkg::ctrl_cmd_t  cmd_o,
  input  b2da_pkg::dp_status_t sts_i
);
  import b2da_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        // A new digit goes out only once the previous beat has left or is taken now.
        if (!sts_i.out_stall) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_conv_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && sts_i.conv_done) |=> state_q == ST_SETUP)
    else $error("conversion did not end in digit setup");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.last) |=> state_q == ST_IDLE)
    else $error("controller did not return to idle after the last digit");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !sts_i.out_stall)
    else $error("digit emitted over a waiting beat");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.shift, cmd_o.setup, cmd_o.emit}))
    else $error("more than one datapath command at once");
`endif

endmodule

// ===== bench/binary_to_decimal_ascii_tb.sv =====
// Testbench for the binary to decimal ASCII converter, with directed, random and stall tests.
module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned MAX_DIGITS = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] src_value;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;
  } digit_beat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_digit_o;

  digit_beat_t pending_digits[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Expected characters of one value, most significant digit first.
  function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
    logic [3:0]         rev [MAX_DIGITS];
    int                 count;
    logic [VALUE_W-1:0] rest;
    digit_beat_t        beat;
    rest = value;
    count = 0;
    do begin
      rev[count] = 4'(rest % 10);
      rest = rest / 10;
      count++;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      beat.src_value = value;
      beat.digit_char = DIGIT_BASE + CHAR_W'(rev[k]);
      beat.last_digit = (k == 0);
      pending_digits.push_back(beat);
    end
  endfunction

  // Called right after a rising edge; returns right after the edge that accepts the beat.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    queue_decimal_digits(value);
  endtask

  // Receiver: random ready, or a forced hold-off while hold_left counts down.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digits.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected digit beat: char %0d last %0b", digit_char_o, last_digit_o);
        end
        mismatch_count++;
      end else begin
        automatic digit_beat_t exp_beat = pending_digits.pop_front();
        if (digit_char_o !== exp_beat.digit_char || last_digit_o !== exp_beat.last_digit) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("value %0d: expected char %0d last %0b, got char %0d last %0b",
                     exp_beat.src_value, exp_beat.digit_char, exp_beat.last_digit,
                     digit_char_o, last_digit_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii test failed");
      $finish;
    end
  end

  // Digit-count boundaries, all-zero and all-one bits, and interior zeros.
  task automatic test_directed();
    logic [VALUE_W-1:0] values [] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd101, 16'd999,
      16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd65535, 16'd65534, 16'd32768,
      16'd32767, 16'd12345, 16'd54321, 16'hAAAA, 16'h5555, 16'd60009, 16'd90,
      16'd50000
    };
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_random(input int count, input int unsigned sender_pct,
                             input int unsigned receiver_pct);
    logic [VALUE_W-1:0] value;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count) begin
      // Spread the values over every digit count, not just five-digit ones.
      case ($urandom_range(9))
        0: value = VALUE_W'($urandom_range(9));
        1: value = VALUE_W'($urandom_range(99, 10));
        2: value = VALUE_W'($urandom_range(999, 100));
        3: value = VALUE_W'($urandom_range(9999, 1000));
        4: value = VALUE_W'($urandom_range(65535, 10000));
        default: value = VALUE_W'($urandom_range(65535));
      endcase
      send_value(value);
    end
  endtask

  // The receiver stalls for a long stretch while values keep coming.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 200;
    repeat (12) send_value(VALUE_W'($urandom_range(65535)));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    value_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(110, 36, 52);
    test_random(110, 52, 36);
    test_output_stall();
    test_random(110, 0, 0);
    in_valid_i <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/b2da_pkg.sv
rtl/core/b2da_datapath.sv
rtl/core/b2da_ctrl.sv
rtl/core/binary_to_decimal_ascii.sv
bench/binary_to_decimal_ascii_tb.sv
